// ----- hdl/buddy_block_allocator_unit_macros.svh -----
// Assertion macros shared by the buddy block allocator sources.
// No dependencies; included by the files that carry assertions.
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication under reset.
`define BBA_ASSERT_HOLD(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buddy allocator check failed");
// Next-cycle implication under reset.
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buddy allocator check failed");
`else
`define BBA_ASSERT_HOLD(lbl, clk, rst_n, ante, cons)
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/bba_pkg.sv -----
// Shared types and constants of the buddy block allocator.
// No dependencies; imported by the walker and the top-level module.
package bba_pkg;

  // Default geometry of the heap.
  localparam int MIN_ORDER_DEF    = 5;
  localparam int MAX_ORDER_DEF    = 19;
  localparam int HEADER_BYTES_DEF = 8;

  // Fixed port widths.
  localparam int ACT_W   = 2;
  localparam int REQ_W   = 32;
  localparam int ADDR_W  = 19;
  localparam int BYTES_W = 20;
  // Internal arithmetic width, wide enough for request plus header.
  localparam int WIDE_W  = 34;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE   = 2'd1;

  typedef enum logic [1:0] {
    NS_FREE  = 2'd0,
    NS_SPLIT = 2'd1,
    NS_USED  = 2'd2
  } node_e;

  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_NOMEM   = 2'd1,
    RES_BADFREE = 2'd2
  } res_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_READ,
    ST_A_EVAL,
    ST_A_BACK,
    ST_A_MARK,
    ST_F_READ,
    ST_F_EVAL,
    ST_M_READ,
    ST_M_EVAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] block_address;
  } cmd_t;

  typedef struct packed {
    res_e               code;
    logic [ADDR_W-1:0]  granted;
    logic [BYTES_W-1:0] avail_bytes;
    logic [BYTES_W-1:0] used_bytes;
  } rsp_t;

endpackage

// ----- hdl/bba_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32767,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/bba_walker.sv -----
// Tree walker of the buddy allocator: clearing pass, allocation search,
// free descent and buddy merge over the node state memory.
// Depends on bba_pkg, bba_ram and the assertion macro header.
`include "buddy_block_allocator_unit_macros.svh"
module bba_walker
  import bba_pkg::*;
#(
  parameter int MIN_ORDER    = MIN_ORDER_DEF,
  parameter int MAX_ORDER    = MAX_ORDER_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  localparam int TD         = MAX_ORDER - MIN_ORDER + 1;
  localparam int NODE_TOTAL = (1 << TD) - 1;
  localparam int LVL_W      = $clog2(TD);
  localparam logic [WIDE_W-1:0] ONE_W = WIDE_W'(1);
  localparam logic [WIDE_W-1:0] HEAP  = ONE_W << MAX_ORDER;
  localparam logic [WIDE_W-1:0] HDR   = WIDE_W'(HEADER_BYTES);
  localparam logic [TD-1:0]     IDX_ONE  = TD'(1);
  localparam logic [TD-1:0]     CLR_LAST = TD'(NODE_TOTAL - 1);

  // Block size of a node at a given tree level.
  function automatic logic [WIDE_W-1:0] lvl_size(input logic [LVL_W-1:0] l);
    return ONE_W << (MAX_ORDER - int'(l));
  endfunction

  state_e              state_q, state_d;
  logic [TD-1:0]       idx_q, idx_d;
  logic [TD-1:0]       clr_q, clr_d;
  logic [LVL_W-1:0]    lvl_q, lvl_d;
  logic [LVL_W-1:0]    want_q, want_d;
  logic [WIDE_W-1:0]   base_q, base_d;
  logic [WIDE_W-1:0]   target_q, target_d;
  logic [WIDE_W-1:0]   granted_q, granted_d;
  logic [WIDE_W-1:0]   free_cnt_q, free_cnt_d;
  res_e                code_q, code_d;

  logic                we, re;
  logic [TD-1:0]       waddr, raddr;
  node_e               wdata;
  logic [1:0]          rdata;
  node_e               node;

  logic [WIDE_W-1:0]   need, addr_w, half;
  logic [LVL_W-1:0]    want_c;
  logic                req_ok, addr_ok;
  logic [TD-1:0]       left_idx, parent_idx;

  bba_ram #(
    .WIDTH(2),
    .DEPTH(NODE_TOTAL),
    .AW   (TD)
  ) u_nodes (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign node = node_e'(rdata);

  // Request decode: header added, smallest fitting level picked.
  always_comb begin
    need    = WIDE_W'(cmd_i.request_bytes) + HDR;
    req_ok  = (cmd_i.request_bytes != '0) && (WIDE_W'(cmd_i.request_bytes) <= HEAP - HDR);
    addr_w  = WIDE_W'(cmd_i.block_address);
    addr_ok = (addr_w >= HDR) && ((addr_w - HDR) < HEAP);
    want_c  = '0;
    for (int l = 0; l < TD; l++) begin
      if (lvl_size(LVL_W'(l)) >= need) begin
        want_c = LVL_W'(l);
      end
    end
  end

  assign left_idx   = (idx_q << 1) + IDX_ONE;
  assign parent_idx = (idx_q - IDX_ONE) >> 1;
  assign half       = lvl_size(lvl_q + LVL_W'(1));

  // Walker state machine.
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    clr_d      = clr_q;
    lvl_d      = lvl_q;
    want_d     = want_q;
    base_d     = base_q;
    target_d   = target_q;
    granted_d  = granted_q;
    free_cnt_d = free_cnt_q;
    code_d     = code_q;
    we         = 1'b0;
    waddr      = idx_q;
    wdata      = NS_FREE;
    re         = 1'b0;
    raddr      = idx_q;
    cmd_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + IDX_ONE;
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          idx_d     = '0;
          lvl_d     = '0;
          base_d    = '0;
          granted_d = '0;
          want_d    = want_c;
          target_d  = addr_w - HDR;
          if (cmd_i.action == ACT_ALLOC) begin
            code_d  = RES_NOMEM;
            state_d = req_ok ? ST_A_READ : ST_DONE;
          end else if (cmd_i.action == ACT_FREE) begin
            code_d  = RES_BADFREE;
            state_d = addr_ok ? ST_F_READ : ST_DONE;
          end else begin
            code_d  = RES_OK;
            state_d = ST_DONE;
          end
        end
      end
      ST_A_READ: begin
        re      = 1'b1;
        state_d = ST_A_EVAL;
      end
      ST_A_EVAL: begin
        case (node)
          NS_FREE: begin
            if (lvl_q == want_q) begin
              we         = 1'b1;
              wdata      = NS_USED;
              granted_d  = base_q + HDR;
              free_cnt_d = free_cnt_q - lvl_size(want_q);
              code_d     = RES_OK;
              state_d    = ST_DONE;
            end else begin
              we      = 1'b1;
              wdata   = NS_SPLIT;
              idx_d   = left_idx;
              lvl_d   = lvl_q + LVL_W'(1);
              state_d = ST_A_MARK;
            end
          end
          NS_SPLIT: begin
            if (lvl_q == want_q) begin
              state_d = ST_A_BACK;
            end else begin
              idx_d   = left_idx;
              lvl_d   = lvl_q + LVL_W'(1);
              state_d = ST_A_READ;
            end
          end
          default: state_d = ST_A_BACK;
        endcase
      end
      ST_A_BACK: begin
        // Step to the right sibling, or climb while on a right child.
        if (idx_q == '0) begin
          state_d = ST_DONE;
        end else if (idx_q[0]) begin
          idx_d   = idx_q + IDX_ONE;
          base_d  = base_q + lvl_size(lvl_q);
          state_d = ST_A_READ;
        end else begin
          idx_d  = parent_idx;
          base_d = base_q - lvl_size(lvl_q);
          lvl_d  = lvl_q - LVL_W'(1);
        end
      end
      ST_A_MARK: begin
        // Split the free chain down the left edge and take its end.
        we = 1'b1;
        if (lvl_q == want_q) begin
          wdata      = NS_USED;
          granted_d  = base_q + HDR;
          free_cnt_d = free_cnt_q - lvl_size(want_q);
          code_d     = RES_OK;
          state_d    = ST_DONE;
        end else begin
          wdata = NS_SPLIT;
          idx_d = left_idx;
          lvl_d = lvl_q + LVL_W'(1);
        end
      end
      ST_F_READ: begin
        re      = 1'b1;
        state_d = ST_F_EVAL;
      end
      ST_F_EVAL: begin
        if (node == NS_USED) begin
          if (base_q == target_q) begin
            we         = 1'b1;
            wdata      = NS_FREE;
            free_cnt_d = free_cnt_q + lvl_size(lvl_q);
            code_d     = RES_OK;
            state_d    = (idx_q == '0) ? ST_DONE : ST_M_READ;
          end else begin
            state_d = ST_DONE;
          end
        end else if (node != NS_SPLIT || lvl_q == LVL_W'(TD - 1)) begin
          state_d = ST_DONE;
        end else begin
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = ST_F_READ;
          if (target_q >= base_q + half) begin
            idx_d  = left_idx + IDX_ONE;
            base_d = base_q + half;
          end else begin
            idx_d = left_idx;
          end
        end
      end
      ST_M_READ: begin
        re      = 1'b1;
        raddr   = idx_q[0] ? idx_q + IDX_ONE : idx_q - IDX_ONE;
        state_d = ST_M_EVAL;
      end
      ST_M_EVAL: begin
        // Merge with a free buddy; a split parent stays split.
        if (node == NS_FREE) begin
          we      = 1'b1;
          waddr   = parent_idx;
          wdata   = NS_FREE;
          idx_d   = parent_idx;
          state_d = (parent_idx == '0) ? ST_DONE : ST_M_READ;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      free_cnt_q <= HEAP;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      free_cnt_q <= free_cnt_d;
    end
  end

  // Walk registers.
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    lvl_q     <= lvl_d;
    want_q    <= want_d;
    base_q    <= base_d;
    target_q  <= target_d;
    granted_q <= granted_d;
    code_q    <= code_d;
  end

  // Result view.
  assign rsp_o.code        = code_q;
  assign rsp_o.granted     = granted_q[ADDR_W-1:0];
  assign rsp_o.avail_bytes = free_cnt_q[BYTES_W-1:0];
  assign rsp_o.used_bytes  = BYTES_W'(HEAP - free_cnt_q);

  `BBA_ASSERT_HOLD(a_cnt_range, clk_i, rst_ni, 1'b1, free_cnt_q <= HEAP)
  `BBA_ASSERT_HOLD(a_mark_level, clk_i, rst_ni, state_q == ST_A_MARK, lvl_q <= want_q)
  `BBA_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_o && !rsp_ready_i, rsp_valid_o && $stable(rsp_o.code))

endmodule

// ----- hdl/buddy_block_allocator_unit.sv -----
// Buddy block allocator: one command beat in, one result beat out.
// The input channel carries an action (allocate, free, status) with its
// request size and block address; the output channel returns a result
// code, the granted address and the free, used and total byte counts.
// All node states live in one memory of 2^(MAX_ORDER-MIN_ORDER+1)-1
// two-bit entries with a registered read.
// Status and rejected commands go from acceptance straight to the done
// state; the next command is taken once their result is in the output register.
// Free reads and evaluates one node per tree level on the way down, then
// reads each buddy and frees the parent per merged level on the way up.
// Allocate reads and evaluates each node of its depth-first search, with
// a backtrack step per move back and a mark write per split level; the
// work grows with fragmentation. One command is in work at a time.
// After reset a clearing pass writes every node free, one per cycle, for
// all 32767 nodes with the default orders; no command is taken meanwhile.
// The result sits in an output register; a new command is accepted while
// it waits, and the next result holds until the receiver takes it.
module buddy_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int MIN_ORDER    = MIN_ORDER_DEF,
  parameter int MAX_ORDER    = MAX_ORDER_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ACT_W-1:0]   action_i,
  input  logic [REQ_W-1:0]   request_bytes_i,
  input  logic [ADDR_W-1:0]  block_address_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         result_code_o,
  output logic [ADDR_W-1:0]  granted_address_o,
  output logic [BYTES_W-1:0] avail_bytes_o,
  output logic [BYTES_W-1:0] used_bytes_o,
  output logic [BYTES_W-1:0] total_bytes_o
);

  localparam logic [WIDE_W-1:0] HEAP = WIDE_W'(1) << MAX_ORDER;

  cmd_t cmd;
  rsp_t rsp, out_q;
  logic rsp_valid, rsp_ready;
  logic out_valid_q, out_valid_d;

  assign cmd.action        = action_i;
  assign cmd.request_bytes = request_bytes_i;
  assign cmd.block_address = block_address_i;

  bba_walker #(
    .MIN_ORDER   (MIN_ORDER),
    .MAX_ORDER   (MAX_ORDER),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(in_valid_i),
    .cmd_ready_o(in_ready_o),
    .cmd_i      (cmd),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp)
  );

  // Output register: loads when empty or being drained.
  assign rsp_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_valid && rsp_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && rsp_ready) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_code_o     = out_q.code;
  assign granted_address_o = out_q.granted;
  assign avail_bytes_o     = out_q.avail_bytes;
  assign used_bytes_o      = out_q.used_bytes;
  assign total_bytes_o     = HEAP[BYTES_W-1:0];

endmodule
